// ===== rtl/rbsr_pkg.sv =====
`default_nettype none
package rbsr_pkg;
    localparam int CoordW = 32;
    localparam int InvW   = 48;
    localparam int DeltaW = 33;
    localparam int FracW  = 17;
    localparam int TShift = 24;
    localparam int NumW   = 34;
    localparam int ProdW  = NumW + InvW;
    localparam int TW     = ProdW - TShift;
    localparam int Axes   = 3;
    localparam int Planes = 6;
    localparam int QuotW  = 41;
    localparam logic [QuotW-1:0] RecipOne = QuotW'(1) << 40;
    // reciprocal is multiplied in 16-bit slices, top slice first
    localparam int ChunkW   = 16;
    localparam int MulSteps = 3;
    localparam int StepW    = 2;
    localparam int PartW    = NumW + ChunkW + 1;

    typedef enum logic [1:0] {
        DIV_IDLE = 2'b01,
        DIV_RUN  = 2'b10
    } div_state_t;

    typedef struct packed {
        logic       both_out;
        logic       entering;
        logic       exiting;
        logic [TW-1:0] t;
    } plane_res_t;
endpackage
`default_nettype wire

// ===== rtl/rbsr_recip.sv =====
`default_nettype none
// Restoring divider: 2^40 / |delta|, negated for negative delta and zero for zero delta, one quotient bit per cycle.
module rbsr_recip
    import rbsr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DeltaW-1:0] delta,
    output logic                   busy,
    output logic                   done,
    output logic [InvW-1:0]        inverse
);
    localparam int CntW = $clog2(QuotW + 1);

    div_state_t          state_reg, state_next;
    logic [CntW-1:0]     cnt_reg, cnt_next;
    logic [QuotW-1:0]    quot_reg, quot_next;
    logic [DeltaW:0]     rem_reg, rem_next;
    logic [DeltaW-1:0]   den_reg, den_next;
    logic                neg_reg, neg_next;
    logic                zero_reg, zero_next;
    logic                done_reg, done_next;
    logic [DeltaW:0]     trial;
    logic [InvW-1:0]     mag;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        neg_next   = neg_reg;
        zero_next  = zero_reg;
        done_next  = 1'b0;
        trial      = {rem_reg[DeltaW-1:0], quot_reg[QuotW-1]};
        case (state_reg)
            DIV_IDLE:
            begin
                if (start)
                begin
                    neg_next   = delta[DeltaW-1];
                    den_next   = delta[DeltaW-1] ? DeltaW'(-delta) : delta;
                    zero_next  = (delta == '0);
                    quot_next  = RecipOne;
                    rem_next   = '0;
                    cnt_next   = CntW'(QuotW);
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN:
            begin
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next  = trial - {1'b0, den_reg};
                    quot_next = {quot_reg[QuotW-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = trial;
                    quot_next = {quot_reg[QuotW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CntW'(1))
                begin
                    state_next = DIV_IDLE;
                    done_next  = 1'b1;
                end
            end
            default: state_next = DIV_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

    assign mag     = InvW'(quot_reg);
    assign inverse = zero_reg ? '0 : (neg_reg ? InvW'(-mag) : mag);
    assign busy    = (state_reg == DIV_RUN);
    assign done    = done_reg;
endmodule
`default_nettype wire

// ===== rtl/rbsr_lane.sv =====
`default_nettype none
// One plane: outside flags, then t built over three multiply steps.
module rbsr_lane
    import rbsr_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     advance,
    input  wire logic                     step,
    input  wire logic [StepW-1:0]         sel,
    input  wire logic                     is_max,
    input  wire logic signed [CoordW-1:0] s,
    input  wire logic signed [CoordW-1:0] e,
    input  wire logic signed [CoordW-1:0] b,
    input  wire logic signed [InvW-1:0]   inv,
    output plane_res_t                    res
);
    logic signed [NumW-1:0]  num;
    logic                    s_out, e_out;
    logic                    both_reg, ent_reg, ext_reg;
    logic signed [NumW-1:0]  num_reg;
    logic signed [InvW-1:0]  inv_reg;
    logic signed [ChunkW:0]  chunk;
    logic signed [PartW-1:0] partial;
    logic signed [ProdW-1:0] acc_reg, acc_next;
    logic signed [ProdW-1:0] adj;

    assign num   = NumW'(s) - NumW'(b);
    assign s_out = is_max ? (s > b) : (s < b);
    assign e_out = is_max ? (e > b) : (e < b);

    // top slice carries the sign, lower slices are unsigned
    always_comb
    begin
        case (sel)
            StepW'(2): chunk = {inv_reg[InvW-1], inv_reg[InvW-1 -: ChunkW]};
            StepW'(1): chunk = {1'b0, inv_reg[2*ChunkW-1 -: ChunkW]};
            default:   chunk = {1'b0, inv_reg[ChunkW-1:0]};
        endcase
    end

    assign partial  = num_reg * chunk;
    assign acc_next = (acc_reg <<< ChunkW) + ProdW'(partial);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            both_reg <= s_out & e_out;
            ent_reg  <= s_out & ~e_out;
            ext_reg  <= ~s_out & e_out;
            num_reg  <= num;
            inv_reg  <= inv;
            acc_reg  <= '0;
        end
        else if (step)
        begin
            acc_reg <= acc_next;
        end
    end

    // floor of product / 2^24 via arithmetic shift
    assign adj          = acc_reg >>> TShift;
    assign res.both_out = both_reg;
    assign res.entering = ent_reg;
    assign res.exiting  = ext_reg;
    assign res.t        = adj[TW-1:0];
endmodule
`default_nettype wire

// ===== rtl/rbsr_merge.sv =====
`default_nettype none
// Walk the six planes in order and narrow the interval.
module rbsr_merge
    import rbsr_pkg::*;
(
    input  plane_res_t        res [Planes],
    input  wire logic [FracW-1:0] limit,
    output logic              rejected
);
    logic signed [TW-1:0] tmin, tmax, tp;
    logic                 rej;

    always_comb
    begin
        tmin = '0;
        tmax = TW'(limit);
        rej  = 1'b0;
        for (int p = 0; p < Planes; p++)
        begin
            tp = res[p].t;
            if (!rej)
            begin
                if (res[p].both_out)
                    rej = 1'b1;
                else if (res[p].entering)
                begin
                    if (tp >= tmax)
                        rej = 1'b1;
                    else if (tp > tmin)
                        tmin = tp;
                end
                else if (res[p].exiting)
                begin
                    if (tmin >= tp)
                        rej = 1'b1;
                    else if (tp < tmax)
                        tmax = tp;
                end
            end
        end
        rejected = rej;
    end
endmodule
`default_nettype wire

// ===== rtl/ray_box_slab_reject_unit.sv =====
`default_nettype none
// Ray/box slab rejection with six plane lanes.
// Box test: capture, three 16-bit multiply steps, then merge into the output register;
// no new request is taken until the result enters the output register, and out_stall
// holds the merge. Ray load: per-axis restoring dividers build 41-bit quotients, then
// each inverse is written to its ray register; no result, input stalls meanwhile.
// Reset (rst_n low, asynchronous) clears ray state to zero and empties the pipeline.
module ray_box_slab_reject_unit
    import rbsr_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     mode,
    input  wire logic signed [CoordW-1:0] first_x,
    input  wire logic signed [CoordW-1:0] first_y,
    input  wire logic signed [CoordW-1:0] first_z,
    input  wire logic signed [CoordW-1:0] second_x,
    input  wire logic signed [CoordW-1:0] second_y,
    input  wire logic signed [CoordW-1:0] second_z,
    input  wire logic [FracW-1:0]         limit_fraction,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic                          rejected
);
    logic signed [CoordW-1:0] start_reg [Axes];
    logic signed [CoordW-1:0] end_reg   [Axes];
    logic signed [InvW-1:0]   inv_reg   [Axes];
    logic [DeltaW-1:0]        delta     [Axes];
    logic [InvW-1:0]          inv_out   [Axes];
    logic [Axes-1:0]          div_busy, div_done;
    logic signed [CoordW-1:0] first_v  [Axes];
    logic signed [CoordW-1:0] second_v [Axes];

    logic                s1_valid_reg;
    logic [FracW-1:0]    s1_limit_reg;
    logic [StepW-1:0]    step_reg;
    logic [StepW-1:0]    sel;
    logic                mul_busy, mul_done;
    logic                out_valid_reg;
    logic                rej_reg;
    logic                advance, in_acc, load_acc, test_acc;
    logic                merged;
    plane_res_t          res [Planes];

    assign first_v[0]  = first_x;
    assign first_v[1]  = first_y;
    assign first_v[2]  = first_z;
    assign second_v[0] = second_x;
    assign second_v[1] = second_y;
    assign second_v[2] = second_z;

    // advance the output register when it is empty or being drained
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = (|div_busy) || (|div_done) || !advance || s1_valid_reg;
    assign in_acc   = in_valid && !in_stall;
    assign load_acc = in_acc && !mode;
    assign test_acc = in_acc && mode;

    // step the lane multipliers, top slice first; hold the test until the last slice
    assign mul_busy = (step_reg != '0);
    assign mul_done = s1_valid_reg && !mul_busy;
    assign sel      = step_reg - StepW'(1);

    for (genvar a = 0; a < Axes; a++)
    begin : g_axis
        assign delta[a] = DeltaW'(first_v[a]) - DeltaW'(second_v[a]);
        rbsr_recip u_recip (
            .clk(clk), .rst_n(rst_n), .start(load_acc), .delta(delta[a]),
            .busy(div_busy[a]), .done(div_done[a]), .inverse(inv_out[a])
        );
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                start_reg[a] <= '0;
                end_reg[a]   <= '0;
                inv_reg[a]   <= '0;
            end
            else
            begin
                if (load_acc)
                begin
                    start_reg[a] <= first_v[a];
                    end_reg[a]   <= second_v[a];
                end
                if (div_done[a])
                    inv_reg[a] <= inv_out[a];
            end
        end
    end

    // lanes 0..2 test min planes, 3..5 max planes
    for (genvar p = 0; p < Planes; p++)
    begin : g_lane
        rbsr_lane u_lane (
            .clk(clk), .advance(test_acc), .step(mul_busy), .sel(sel),
            .is_max(p >= Axes),
            .s(start_reg[p % Axes]), .e(end_reg[p % Axes]),
            .b((p >= Axes) ? second_v[p % Axes] : first_v[p % Axes]),
            .inv(inv_reg[p % Axes]), .res(res[p])
        );
    end

    rbsr_merge u_merge (.res(res), .limit(s1_limit_reg), .rejected(merged));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (test_acc)
            begin
                s1_valid_reg <= 1'b1;
                step_reg     <= StepW'(MulSteps);
            end
            else if (mul_busy)
            begin
                step_reg <= step_reg - StepW'(1);
            end
            else if (mul_done && advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
                out_valid_reg <= mul_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (test_acc)
            s1_limit_reg <= limit_fraction;
        if (advance && mul_done)
            rej_reg <= merged;
    end

    assign out_valid = out_valid_reg;
    assign rejected  = rej_reg;

`ifndef SYNTHESIS
    // hold off requests while a reciprocal is being built
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (|div_busy) |-> in_stall) else $error("request taken during load");
    // a load request starts all three dividers
    a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
        load_acc |=> (&div_busy)) else $error("divider not started");
    // a result only follows a test request
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(s1_valid_reg)) else $error("spurious result");
`endif
endmodule
`default_nettype wire
